// File: rtl/cau_pkg.sv
package cau_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;
  localparam int WW = PW + 1;
  localparam int NCELL = DW;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic                  dz;
    logic                  ovf_re;
    logic                  ovf_im;
    logic                  neg_re;
    logic                  neg_im;
    logic signed [WW-1:0]  wide_re;
    logic signed [WW-1:0]  wide_im;
    logic [PW-1:0]         den;
  } side_t;

  typedef struct packed {
    logic [PW-1:0] r_re;
    logic [PW-1:0] r_im;
    logic [DW-1:0] q_re;
    logic [DW-1:0] q_im;
    logic [PW-1:0] lo_re;
    logic [DW-1:0] lo_im;
  } lane_t;

  typedef struct packed {
    side_t side;
    lane_t lane;
  } beat_t;

endpackage

// File: rtl/cau_in_if.sv
interface cau_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   cmd;
  logic signed [cau_pkg::DW-1:0] a_re;
  logic signed [cau_pkg::DW-1:0] a_im;
  logic signed [cau_pkg::DW-1:0] b_re;
  logic signed [cau_pkg::DW-1:0] b_im;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: rtl/cau_out_if.sv
interface cau_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [cau_pkg::DW-1:0] res_re;
  logic signed [cau_pkg::DW-1:0] res_im;
  logic                         zero_divisor;
  logic                         saturated;

  modport source (output valid, res_re, res_im, zero_divisor, saturated, input ready);
  modport sink (input valid, res_re, res_im, zero_divisor, saturated, output ready);
endinterface

// File: rtl/complex_arithmetic_unit.sv
// pipeline: 3 front stages, 32 cells and an output stage between input beat and result beat
// throughput: one beat per cycle while out_o.ready is high; each cell forms one quotient or root bit
// every stage stalls only while it holds a beat its successor cannot take, so bubbles are squeezed out
// reset: asynchronous, active low; clears all valid flags, payload registers keep their contents
module complex_arithmetic_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  logic  valid_c [NCELL+1];
  logic  ready_c [NCELL+1];
  beat_t beat_c  [NCELL+1];

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .beat_o  (beat_c[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .beat_i  (beat_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .beat_o  (beat_c[i+1])
    );
  end

  cau_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[NCELL]),
    .ready_o (ready_c[NCELL]),
    .beat_i  (beat_c[NCELL]),
    .out_o   (out_o)
  );

endmodule

// File: rtl/cau_front.sv
module cau_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  cau_in_if.sink         in_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cau_pkg::beat_t beat_o
);
  import cau_pkg::*;

  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c;

  cmd_e                 cmd_a_q, cmd_b_q;
  logic signed [DW-1:0] ar_q, ai_q, br_q, bi_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_q, p_b2_q, p_aa_q, p_a2_q;
  logic signed [WW-1:0] wre_d, wim_d, wre_q, wim_q;
  logic [PW-1:0]        den_d, den_q;
  logic [WW-1:0]        neg_re_v, neg_im_v;
  logic [PW-1:0]        mag_re, mag_im;
  logic [PW+FB-1:0]     num_re, num_im;
  beat_t                beat_d, beat_q;

  assign rdy_c = !vc_q || ready_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_i.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_i.valid;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (rdy_a && in_i.valid) begin
      cmd_a_q <= cmd_e'(in_i.cmd);
      ar_q    <= in_i.a_re;
      ai_q    <= in_i.a_im;
      br_q    <= in_i.b_re;
      bi_q    <= in_i.b_im;
      p_rr_q  <= PW'(in_i.a_re * in_i.b_re);
      p_ii_q  <= PW'(in_i.a_im * in_i.b_im);
      p_ir_q  <= PW'(in_i.a_im * in_i.b_re);
      p_ri_q  <= PW'(in_i.a_re * in_i.b_im);
      p_bb_q  <= PW'(in_i.b_re * in_i.b_re);
      p_b2_q  <= PW'(in_i.b_im * in_i.b_im);
      p_aa_q  <= PW'(in_i.a_re * in_i.a_re);
      p_a2_q  <= PW'(in_i.a_im * in_i.a_im);
    end
  end

  // sums and differences
  always_comb begin
    wre_d = '0;
    wim_d = '0;
    case (cmd_a_q)
      CMD_ADD: begin
        wre_d = WW'(ar_q) + WW'(br_q);
        wim_d = WW'(ai_q) + WW'(bi_q);
      end
      CMD_SUB: begin
        wre_d = WW'(ar_q) - WW'(br_q);
        wim_d = WW'(ai_q) - WW'(bi_q);
      end
      CMD_MUL: begin
        wre_d = WW'(p_rr_q) - WW'(p_ii_q);
        wim_d = WW'(p_ir_q) + WW'(p_ri_q);
      end
      CMD_DIV: begin
        wre_d = WW'(p_rr_q) + WW'(p_ii_q);
        wim_d = WW'(p_ir_q) - WW'(p_ri_q);
      end
      CMD_MAG: begin
        wre_d = WW'(p_aa_q) + WW'(p_a2_q);
      end
      default: begin
        wre_d = '0;
        wim_d = '0;
      end
    endcase
    den_d = $unsigned(p_bb_q) + $unsigned(p_b2_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      cmd_b_q <= cmd_a_q;
      wre_q   <= wre_d;
      wim_q   <= wim_d;
      den_q   <= den_d;
    end
  end

  // magnitudes, zero divisor and overflow tests, divider and root seed
  always_comb begin
    neg_re_v = WW'(-wre_q);
    neg_im_v = WW'(-wim_q);
    mag_re   = wre_q[WW-1] ? neg_re_v[PW-1:0] : wre_q[PW-1:0];
    mag_im   = wim_q[WW-1] ? neg_im_v[PW-1:0] : wim_q[PW-1:0];
    num_re   = {mag_re, {FB{1'b0}}};
    num_im   = {mag_im, {FB{1'b0}}};

    beat_d.side.cmd     = cmd_b_q;
    beat_d.side.dz      = (cmd_b_q == CMD_DIV) && (den_q == '0);
    beat_d.side.neg_re  = wre_q[WW-1];
    beat_d.side.neg_im  = wim_q[WW-1];
    beat_d.side.ovf_re  = (PW+DW)'(num_re) >= {den_q, {DW{1'b0}}};
    beat_d.side.ovf_im  = (PW+DW)'(num_im) >= {den_q, {DW{1'b0}}};
    beat_d.side.wide_re = wre_q;
    beat_d.side.wide_im = wim_q;
    beat_d.side.den     = den_q;

    beat_d.lane.q_re  = '0;
    beat_d.lane.q_im  = '0;
    beat_d.lane.r_im  = PW'(num_im >> DW);
    beat_d.lane.lo_im = num_im[DW-1:0];
    if (cmd_b_q == CMD_MAG) begin
      beat_d.lane.r_re  = '0;
      beat_d.lane.lo_re = wre_q[PW-1:0];
    end else begin
      beat_d.lane.r_re  = PW'(num_re >> DW);
      beat_d.lane.lo_re = {num_re[DW-1:0], {(PW-DW){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) beat_q <= beat_d;
  end

  assign valid_o = vc_q;
  assign beat_o  = beat_q;

endmodule

// File: rtl/cau_cell.sv
module cau_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cau_pkg::beat_t beat_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cau_pkg::beat_t beat_o
);
  import cau_pkg::*;

  logic          valid_q;
  beat_t         beat_q, beat_d;
  logic [PW:0]   t_re, t_im, dv;
  logic [PW-1:0] ts, trial;
  logic          ge_re, ge_im, ge_s;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dv    = {1'b0, beat_i.side.den};
    t_re  = {beat_i.lane.r_re, beat_i.lane.lo_re[PW-1]};
    t_im  = {beat_i.lane.r_im, beat_i.lane.lo_im[DW-1]};
    ge_re = t_re >= dv;
    ge_im = t_im >= dv;
    // one root bit: remainder gets the next two radicand bits
    ts    = {beat_i.lane.r_re[PW-3:0], beat_i.lane.lo_re[PW-1:PW-2]};
    trial = {{(PW-DW-2){1'b0}}, beat_i.lane.q_re, 2'b01};
    ge_s  = ts >= trial;

    beat_d            = beat_i;
    beat_d.lane.lo_im = beat_i.lane.lo_im << 1;
    beat_d.lane.q_im  = {beat_i.lane.q_im[DW-2:0], ge_im};
    beat_d.lane.r_im  = ge_im ? PW'(t_im - dv) : t_im[PW-1:0];
    if (beat_i.side.cmd == CMD_MAG) begin
      beat_d.lane.lo_re = beat_i.lane.lo_re << 2;
      beat_d.lane.q_re  = {beat_i.lane.q_re[DW-2:0], ge_s};
      beat_d.lane.r_re  = ge_s ? ts - trial : ts;
    end else begin
      beat_d.lane.lo_re = beat_i.lane.lo_re << 1;
      beat_d.lane.q_re  = {beat_i.lane.q_re[DW-2:0], ge_re};
      beat_d.lane.r_re  = ge_re ? PW'(t_re - dv) : t_re[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: rtl/cau_back.sv
module cau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cau_pkg::beat_t beat_i,
  cau_out_if.source      out_o
);
  import cau_pkg::*;

  logic                 valid_q;
  logic signed [WW-1:0] v_re, v_im;
  logic signed [WW-1:0] big_pos, big_neg;
  logic [DW:0]          qs_re, qs_im;
  logic                 hi_re, lo_re, hi_im, lo_im;
  logic [DW-1:0]        c_re, c_im;
  logic signed [DW-1:0] res_re_q, res_im_q;
  logic                 dz_q, sat_q;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    big_pos = WW'(1) <<< DW;
    big_neg = -big_pos;
    qs_re   = beat_i.side.neg_re ? -{1'b0, beat_i.lane.q_re} : {1'b0, beat_i.lane.q_re};
    qs_im   = beat_i.side.neg_im ? -{1'b0, beat_i.lane.q_im} : {1'b0, beat_i.lane.q_im};
    v_re = '0;
    v_im = '0;
    case (beat_i.side.cmd)
      CMD_ADD, CMD_SUB: begin
        v_re = beat_i.side.wide_re;
        v_im = beat_i.side.wide_im;
      end
      CMD_MUL: begin
        v_re = beat_i.side.wide_re >>> FB;
        v_im = beat_i.side.wide_im >>> FB;
      end
      CMD_DIV: begin
        if (!beat_i.side.dz) begin
          if (beat_i.side.ovf_re) v_re = beat_i.side.neg_re ? big_neg : big_pos;
          else                    v_re = WW'($signed(qs_re));
          if (beat_i.side.ovf_im) v_im = beat_i.side.neg_im ? big_neg : big_pos;
          else                    v_im = WW'($signed(qs_im));
        end
      end
      CMD_MAG: begin
        v_re = WW'(beat_i.lane.q_re);
      end
      default: begin
        v_re = '0;
        v_im = '0;
      end
    endcase
    hi_re = !v_re[WW-1] && (|v_re[WW-2:DW-1]);
    lo_re = v_re[WW-1] && !(&v_re[WW-2:DW-1]);
    hi_im = !v_im[WW-1] && (|v_im[WW-2:DW-1]);
    lo_im = v_im[WW-1] && !(&v_im[WW-2:DW-1]);
    c_re  = hi_re ? {1'b0, {(DW-1){1'b1}}} : lo_re ? {1'b1, {(DW-1){1'b0}}} : v_re[DW-1:0];
    c_im  = hi_im ? {1'b0, {(DW-1){1'b1}}} : lo_im ? {1'b1, {(DW-1){1'b0}}} : v_im[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_re_q <= $signed(c_re);
      res_im_q <= $signed(c_im);
      dz_q     <= beat_i.side.dz;
      sat_q    <= hi_re || lo_re || hi_im || lo_im;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.res_re       = res_re_q;
  assign out_o.res_im       = res_im_q;
  assign out_o.zero_divisor = dz_q;
  assign out_o.saturated    = sat_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_divisor |->
      out_o.res_re == '0 && out_o.res_im == '0 && !out_o.saturated)
    else $error("zero divisor beat with nonzero result");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.res_re == {1'b0, {(DW-1){1'b1}}} || out_o.res_re == {1'b1, {(DW-1){1'b0}}} ||
      out_o.res_im == {1'b0, {(DW-1){1'b1}}} || out_o.res_im == {1'b1, {(DW-1){1'b0}}})
    else $error("saturated beat without a clipped part");

  a_mag_im: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && beat_i.side.cmd == CMD_MAG |=> out_o.res_im == '0)
    else $error("magnitude beat with nonzero imaginary part");

endmodule
